// ===== rtl/mcsa_pkg.sv =====
package mcsa_pkg;

   localparam int SpacingWidth = 24;
   localparam int ProdWidth    = 2 * SpacingWidth;
   localparam int SquareWidth  = 2 * ProdWidth;
   localparam int AccWidth     = SquareWidth + 8;
   localparam int RootWidth    = AccWidth / 2;
   localparam int AreaWidth    = 56;
   localparam int AreaShift    = 19;
   localparam int KsqWidth     = 7;

   localparam logic [SpacingWidth-1:0] SpacingOne = 24'h010000;

   localparam logic [5:0] ProdSteps   = 6'd24;
   localparam logic [5:0] SquareSteps = 6'd48;
   localparam logic [5:0] KsqSteps    = 6'd7;
   localparam logic [5:0] RootSteps   = 6'd52;

   localparam logic [2:0] MaxTriangles = 3'd5;
   localparam logic [3:0] EdgeNone     = 4'hf;

   typedef enum logic [1:0] {
      CSR_SPACING_Z = 2'd0,
      CSR_SPACING_Y = 2'd1,
      CSR_SPACING_X = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLOAD,
      ST_PMUL,
      ST_QLOAD,
      ST_QMUL,
      ST_TRI,
      ST_KLOAD,
      ST_KMUL,
      ST_RLOAD,
      ST_ROOT,
      ST_ACC,
      ST_FINISH
   } state_type;

   typedef logic [KsqWidth-1:0] ksq_type [3];

   // edges of up to five triangles per folded index, first edge in the top nibble
   localparam logic [59:0] TriTable [128] = '{
      60'hfffffffffffffff, 60'h083ffffffffffff, 60'h019ffffffffffff, 60'h183981fffffffff,
      60'h12affffffffffff, 60'h08312afffffffff, 60'h92a029fffffffff, 60'h2832a8a98ffffff,
      60'h3b2ffffffffffff, 60'h0b28b0fffffffff, 60'h19023bfffffffff, 60'h1b219b98bffffff,
      60'h3a1ba3fffffffff, 60'h0a108a8baffffff, 60'h3903b9ba9ffffff, 60'h98aa8bfffffffff,
      60'h478ffffffffffff, 60'h430734fffffffff, 60'h019847fffffffff, 60'h419471731ffffff,
      60'h12a847fffffffff, 60'h34730412affffff, 60'h92a902847ffffff, 60'h2a9297273794fff,
      60'h8473b2fffffffff, 60'hb47b24204ffffff, 60'h90184723bffffff, 60'h47b94b9b2921fff,
      60'h3a13ba784ffffff, 60'h1ba14b1047b4fff, 60'h47890b9bab03fff, 60'h47b4b99baffffff,
      60'h954ffffffffffff, 60'h954083fffffffff, 60'h054150fffffffff, 60'h854835315ffffff,
      60'h12a954fffffffff, 60'h30812a495ffffff, 60'h52a542402ffffff, 60'h2a5325354348fff,
      60'h95423bfffffffff, 60'h0b208b495ffffff, 60'h05401523bffffff, 60'h21525828b485fff,
      60'ha3ba13954ffffff, 60'h4950818a18bafff, 60'h54050b5bab03fff, 60'h54858aa8bffffff,
      60'h978579fffffffff, 60'h930953573ffffff, 60'h078017157ffffff, 60'h153357fffffffff,
      60'h978957a12ffffff, 60'ha12950530573fff, 60'h802825857a52fff, 60'h2a5253357ffffff,
      60'h7957893b2ffffff, 60'h95797292027bfff, 60'h23b018178157fff, 60'hb21b17715ffffff,
      60'h958857a13a3bfff, 60'h5705097b010aba0, 60'hba0b03a50807570, 60'hba57b5fffffffff,
      60'ha65ffffffffffff, 60'h0835a6fffffffff, 60'h9015a6fffffffff, 60'h1831985a6ffffff,
      60'h165261fffffffff, 60'h165126308ffffff, 60'h965906026ffffff, 60'h598582526328fff,
      60'h23ba65fffffffff, 60'hb08b20a65ffffff, 60'h01923b5a6ffffff, 60'h5a61929b298bfff,
      60'h63b653513ffffff, 60'h08b0b50515b6fff, 60'h3b6036065059fff, 60'h65969bb98ffffff,
      60'h5a6478fffffffff, 60'h43047365affffff, 60'h1905a6847ffffff, 60'ha65197173794fff,
      60'h612651478ffffff, 60'h125526304347fff, 60'h847905065026fff, 60'h739794329596269,
      60'h3b2784a65ffffff, 60'h5a647242027bfff, 60'h01947823b5a6fff, 60'h9219b294b7b45a6,
      60'h8473b53515b6fff, 60'h51b5b610b7b404b, 60'h059065036b63847, 60'h65969b4797b9fff,
      60'ha4964afffffffff, 60'h4a649a083ffffff, 60'ha01a60640ffffff, 60'h83181686461afff,
      60'h149124264ffffff, 60'h308129249264fff, 60'h024426fffffffff, 60'h832824426ffffff,
      60'ha49a64b23ffffff, 60'h08228b49a4a6fff, 60'h3b201606461afff, 60'h64161a48121b8b1,
      60'h964936913b63fff, 60'h8b1810b61914641, 60'h3b6360064ffffff, 60'h648b68fffffffff,
      60'h7a678a89affffff, 60'h0730a709a67afff, 60'ha671a7178180fff, 60'ha67a71173ffffff,
      60'h126168189867fff, 60'h269291679093739, 60'h780706602ffffff, 60'h732672fffffffff,
      60'h23ba68a89867fff, 60'h20727b09767a9a7, 60'h1801781a767a23b, 60'hb21b17a61671fff,
      60'h896867916b63136, 60'h091b67fffffffff, 60'h7807063b0b60fff, 60'h7b6ffffffffffff
   };

   // edge midpoint in half-voxel units, {z, y, x}
   function automatic logic [5:0] edge_mid(input logic [3:0] e);
      logic [5:0] m;
      case (e)
         4'd0:    m = {2'd0, 2'd0, 2'd1};
         4'd1:    m = {2'd0, 2'd1, 2'd2};
         4'd2:    m = {2'd0, 2'd2, 2'd1};
         4'd3:    m = {2'd0, 2'd1, 2'd0};
         4'd4:    m = {2'd2, 2'd0, 2'd1};
         4'd5:    m = {2'd2, 2'd1, 2'd2};
         4'd6:    m = {2'd2, 2'd2, 2'd1};
         4'd7:    m = {2'd2, 2'd1, 2'd0};
         4'd8:    m = {2'd1, 2'd0, 2'd0};
         4'd9:    m = {2'd1, 2'd0, 2'd2};
         4'd10:   m = {2'd1, 2'd2, 2'd2};
         4'd11:   m = {2'd1, 2'd2, 2'd0};
         default: m = 6'd0;
      endcase
      return m;
   endfunction

   // squared components of the half-unit cross product, in y*x, z*x, z*y order
   function automatic ksq_type tri_ksq(input logic [3:0] e0, input logic [3:0] e1,
                                       input logic [3:0] e2);
      logic [5:0] m0, m1, m2;
      logic signed [3:0] a [3];
      logic signed [3:0] b [3];
      logic signed [7:0] k [3];
      logic [7:0] sq;
      ksq_type r;
      m0 = edge_mid(e0);
      m1 = edge_mid(e1);
      m2 = edge_mid(e2);
      for (int d = 0; d < 3; d++) begin
         a[d] = $signed({2'b00, m1[5-2*d -: 2]}) - $signed({2'b00, m0[5-2*d -: 2]});
         b[d] = $signed({2'b00, m2[5-2*d -: 2]}) - $signed({2'b00, m0[5-2*d -: 2]});
      end
      k[0] = 8'(a[1] * b[2]) - 8'(b[1] * a[2]);
      k[1] = 8'(a[2] * b[0]) - 8'(b[2] * a[0]);
      k[2] = 8'(a[0] * b[1]) - 8'(b[0] * a[1]);
      for (int d = 0; d < 3; d++) begin
         sq = 8'(k[d] * k[d]);
         r[d] = sq[KsqWidth-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/marching_cubes_surface_area.sv =====
// channel | dir | tdata                    | tuser          | tlast
// req     | in  | corner_bits[7:0]         | -              | last_cube
// rsp     | out | surface_area[55:0]       | area_saturated | -
// csr     | in  | csr_wdata = spacing Q8.16, csr_addr = register index
// empty or full cube skips to finish; first non-empty cube after a spacing write recomputes
// spacing products and squares; each triangle runs shift-add multiplies, then bit-serial root
// one transaction at a time; the shift-add unit and the root iterate on one adder each
// reset clears totals, result register and spacing cache, spacings return to 1.0
// a stalled result does not block the next cube, only the next result
module marching_cubes_surface_area (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,    // corner_bits
   input  logic                              req_tlast,    // last_cube
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [55:0]                       rsp_tdata,    // surface_area
   output logic                              rsp_tuser,    // area_saturated
   input  logic                              csr_we,
   input  logic [1:0]                        csr_addr,
   input  logic [mcsa_pkg::SpacingWidth-1:0] csr_wdata
);

   localparam int SpacingWidth = mcsa_pkg::SpacingWidth;
   localparam int PW = mcsa_pkg::ProdWidth;
   localparam int QW = mcsa_pkg::SquareWidth;
   localparam int AW = mcsa_pkg::AccWidth;
   localparam int RW = mcsa_pkg::RootWidth;
   localparam int ZW = mcsa_pkg::AreaWidth;

   mcsa_pkg::state_type state_ff, state_in;

   logic [SpacingWidth-1:0] sp_z_ff, sp_y_ff, sp_x_ff;
   logic                    cache_ok_ff, cache_ok_in;
   logic [PW-1:0]           p_ff [3];
   logic [QW-1:0]           q_ff [3];
   logic [PW-1:0]           p_in;
   logic [QW-1:0]           q_in;
   logic                    p_we, q_we;
   mcsa_pkg::ksq_type       ksq_ff, ksq_in;

   logic [6:0]  idx_ff, idx_in;
   logic        last_ff, last_in;
   logic [1:0]  comp_ff, comp_in;
   logic [2:0]  tri_ff, tri_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic [AW-1:0] prod_ff, prod_in, mcand_ff, mcand_in;
   logic [PW-1:0] mplier_ff, mplier_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW:0]   rem_ff, rem_in;

   logic [ZW-1:0] total_ff, total_in;
   logic          ovf_ff, ovf_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [ZW-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_sat_ff, rsp_sat_in;

   logic [AW-1:0]       step_prod;
   logic [RW+2:0]       rem_sh, trial, rem_diff;
   logic [59:0]         row;
   logic [59:0]         row_sh;
   logic [SpacingWidth-1:0] op_a, op_b;
   logic [ZW:0]         sum_area;
   logic [7:0]          fold;
   logic                req_fire;
   mcsa_pkg::ksq_type   ksq_tri;

   assign req_tready = (state_ff == mcsa_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   assign fold      = req_tdata[7] ? ~req_tdata : req_tdata;
   assign step_prod = prod_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign rem_sh    = {rem_ff, mcand_ff[AW-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign rem_diff  = rem_sh - trial;
   assign row       = mcsa_pkg::TriTable[idx_ff];
   assign row_sh    = row << (6'(tri_ff) * 6'd12);
   assign ksq_tri   = mcsa_pkg::tri_ksq(row_sh[59:56], row_sh[55:52], row_sh[51:48]);
   assign sum_area  = {1'b0, total_ff} + (ZW+1)'(root_ff[RW-1:mcsa_pkg::AreaShift]);

   always_comb begin
      unique case (comp_ff)
         2'd0:    begin op_a = sp_y_ff; op_b = sp_x_ff; end
         2'd1:    begin op_a = sp_z_ff; op_b = sp_x_ff; end
         default: begin op_a = sp_z_ff; op_b = sp_y_ff; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cache_ok_in  = cache_ok_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      comp_in      = comp_ff;
      tri_in       = tri_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      ksq_in       = ksq_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      p_we         = 1'b0;
      q_we         = 1'b0;
      p_in         = step_prod[PW-1:0];
      q_in         = step_prod[QW-1:0];

      unique case (state_ff)
         mcsa_pkg::ST_IDLE: begin
            if (req_fire) begin
               idx_in  = fold[6:0];
               last_in = req_tlast;
               tri_in  = '0;
               comp_in = '0;
               if (fold[6:0] == 7'd0) begin
                  state_in = mcsa_pkg::ST_FINISH;
               end else if (cache_ok_ff) begin
                  state_in = mcsa_pkg::ST_TRI;
               end else begin
                  state_in = mcsa_pkg::ST_PLOAD;
               end
            end
         end
         mcsa_pkg::ST_PLOAD: begin
            prod_in   = '0;
            mcand_in  = AW'(op_a);
            mplier_in = PW'(op_b);
            cnt_in    = mcsa_pkg::ProdSteps;
            state_in  = mcsa_pkg::ST_PMUL;
         end
         mcsa_pkg::ST_PMUL: begin
            prod_in   = step_prod;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               p_we = 1'b1;
               if (comp_ff == 2'd2) begin
                  comp_in  = '0;
                  state_in = mcsa_pkg::ST_QLOAD;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = mcsa_pkg::ST_PLOAD;
               end
            end
         end
         mcsa_pkg::ST_QLOAD: begin
            prod_in   = '0;
            mcand_in  = AW'(p_ff[comp_ff]);
            mplier_in = p_ff[comp_ff];
            cnt_in    = mcsa_pkg::SquareSteps;
            state_in  = mcsa_pkg::ST_QMUL;
         end
         mcsa_pkg::ST_QMUL: begin
            prod_in   = step_prod;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               q_we = 1'b1;
               if (comp_ff == 2'd2) begin
                  comp_in     = '0;
                  cache_ok_in = 1'b1;
                  state_in    = mcsa_pkg::ST_TRI;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = mcsa_pkg::ST_QLOAD;
               end
            end
         end
         mcsa_pkg::ST_TRI: begin
            if (tri_ff == mcsa_pkg::MaxTriangles || row_sh[59:56] == mcsa_pkg::EdgeNone) begin
               state_in = mcsa_pkg::ST_FINISH;
            end else begin
               ksq_in   = ksq_tri;
               prod_in  = '0;
               comp_in  = '0;
               state_in = mcsa_pkg::ST_KLOAD;
            end
         end
         mcsa_pkg::ST_KLOAD: begin
            mcand_in  = AW'(q_ff[comp_ff]);
            mplier_in = PW'(ksq_ff[comp_ff]);
            cnt_in    = mcsa_pkg::KsqSteps;
            state_in  = mcsa_pkg::ST_KMUL;
         end
         mcsa_pkg::ST_KMUL: begin
            prod_in   = step_prod;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               if (comp_ff == 2'd2) begin
                  state_in = mcsa_pkg::ST_RLOAD;
               end else begin
                  comp_in  = comp_ff + 2'd1;
                  state_in = mcsa_pkg::ST_KLOAD;
               end
            end
         end
         mcsa_pkg::ST_RLOAD: begin
            mcand_in = prod_ff;
            root_in  = '0;
            rem_in   = '0;
            cnt_in   = mcsa_pkg::RootSteps;
            state_in = mcsa_pkg::ST_ROOT;
         end
         mcsa_pkg::ST_ROOT: begin
            mcand_in = mcand_ff << 2;
            cnt_in   = cnt_ff - 6'd1;
            if (rem_sh >= trial) begin
               rem_in  = rem_diff[RW:0];
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[RW:0];
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            if (cnt_ff == 6'd1) begin
               state_in = mcsa_pkg::ST_ACC;
            end
         end
         mcsa_pkg::ST_ACC: begin
            if (sum_area[ZW]) begin
               total_in = '1;
               ovf_in   = 1'b1;
            end else begin
               total_in = sum_area[ZW-1:0];
            end
            tri_in   = tri_ff + 3'd1;
            state_in = mcsa_pkg::ST_TRI;
         end
         mcsa_pkg::ST_FINISH: begin
            if (!last_ff) begin
               state_in = mcsa_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = total_ff;
               rsp_sat_in   = ovf_ff;
               total_in     = '0;
               ovf_in       = 1'b0;
               state_in     = mcsa_pkg::ST_IDLE;
            end
         end
         default: state_in = mcsa_pkg::ST_IDLE;
      endcase

      if (csr_we) begin
         cache_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcsa_pkg::ST_IDLE;
         cache_ok_ff  <= 1'b0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sp_z_ff      <= mcsa_pkg::SpacingOne;
         sp_y_ff      <= mcsa_pkg::SpacingOne;
         sp_x_ff      <= mcsa_pkg::SpacingOne;
      end else begin
         state_ff     <= state_in;
         cache_ok_ff  <= cache_ok_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               mcsa_pkg::CSR_SPACING_Z: sp_z_ff <= csr_wdata;
               mcsa_pkg::CSR_SPACING_Y: sp_y_ff <= csr_wdata;
               mcsa_pkg::CSR_SPACING_X: sp_x_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      comp_ff     <= comp_in;
      tri_ff      <= tri_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      ksq_ff      <= ksq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
      if (p_we) begin
         p_ff[comp_ff] <= p_in;
      end
      if (q_we) begin
         q_ff[comp_ff] <= q_in;
      end
   end

endmodule

// ===== rtl/mcsa_checker.sv =====
module mcsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result changed while stalled");

   // busy after each transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while busy");

   // saturated area reads as full scale
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (&rsp_tdata))
      else $error("saturation flag without full-scale area");

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind marching_cubes_surface_area mcsa_checker u_mcsa_checker (.*);
